// ===== hdl/encoder_multiturn_unwrap_scale_top_assert.svh =====
// assertion macros for the encoder unwrap and scale block
`ifndef ENCODER_MULTITURN_UNWRAP_SCALE_TOP_ASSERT_SVH
`define ENCODER_MULTITURN_UNWRAP_SCALE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define EMUS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define EMUS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/emus_pkg.sv =====
// package with types and constants of the encoder unwrap and scale block
`timescale 1ns / 1ps

package emus_pkg;

  localparam int CHANNELS   = 4;
  localparam int CH_W       = 2;
  localparam int NUM_SLOTS  = 2 ** CH_W;
  localparam int RANGE_W    = 33;
  localparam int SCALE_W    = 32;
  localparam int RAW_W      = 32;
  localparam int TURN_W     = 32;
  localparam int HOME_W     = 48;
  localparam int POS_W      = 64;
  localparam int PROD_W     = 96;
  localparam int MUL_W      = 34;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 33;

  localparam logic [CH_W:0]        CH_LIMIT    = (CH_W + 1)'(CHANNELS);
  localparam logic [RANGE_W-1:0]   RANGE_RESET = 33'd65536;
  localparam logic [RANGE_W-1:0]   RANGE_MIN   = 33'd2;
  localparam logic [RANGE_W-1:0]   RANGE_MAX   = 33'h1_0000_0000;
  localparam logic [SCALE_W-1:0]   SCALE_RESET = 32'h0100_0000;
  localparam logic [POS_W-1:0]     POS_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [POS_W-1:0]     POS_MIN     = 64'h8000_0000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE  = 3'd0,
    REG_SCALE0 = 3'd1,
    REG_SCALE1 = 3'd2,
    REG_SCALE2 = 3'd3,
    REG_SCALE3 = 3'd4
  } emus_reg_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_HOME   = 1'b1
  } emus_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TURN,
    S_MEXT,
    S_ADD,
    S_MLO,
    S_MHI,
    S_SUM,
    S_FIN
  } emus_state_e;

  typedef struct packed {
    logic                     opcode;
    logic [CH_W-1:0]          channel;
    logic [RAW_W-1:0]         raw_count;
    logic signed [HOME_W-1:0] home_value;
  } emus_in_t;

  typedef struct packed {
    logic [CH_W-1:0]         channel_out;
    logic signed [POS_W-1:0] position;
  } emus_out_t;

endpackage

// ===== hdl/emus_if.sv =====
// valid/ready channel interfaces for items in and results out
`timescale 1ns / 1ps

interface emus_in_if;
  import emus_pkg::*;

  logic     valid;
  logic     ready;
  emus_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface emus_out_if;
  import emus_pkg::*;

  logic      valid;
  logic      ready;
  emus_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/encoder_multiturn_unwrap_scale_top.sv =====
// encoder multiturn unwrap, scale and homing block with a shared multiplier
// usage:
//   in_if carries one item per transfer: opcode, channel, raw_count, home_value.
//   a sample item unwraps the raw count into turns, scales it by the channel's
//   Q8.24 factor, subtracts the homing bias and returns one saturated Q40.24
//   position on out_if. a home item restarts the channel's unwrap from zero and updates its bias, no result.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the range and the four scale factors;
//   the user writes them only while the block is idle; the block does not enforce it.
// timing:
//   an item is accepted in the idle state and then passes seven sequencer steps
//   (turn, mext, add, mlo, mhi, sum, fin); the 34x34 multiplier is used three
//   times per item (turns times range, low and high halves of the count times
//   scale). a sample result is registered in the fin step.
//   in_if.ready is high only while the sequencer is idle.
// reset:
//   turn counts, last counts and biases clear to zero, range to 65536 and
//   scales to 1.0; no result is pending.
// stall:
//   a held result stays on out_if; a new item may be worked on meanwhile,
//   and a sample item's last step waits until the output register is free.
`timescale 1ns / 1ps

module encoder_multiturn_unwrap_scale_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  emus_in_if.sink                          in_if,
  emus_out_if.source                       out_if,
  input  logic                             cfg_we_i,
  input  logic [emus_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [emus_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import emus_pkg::*;

  emus_state_e state_q, state_d;

  logic [RANGE_W-1:0]      range_q;
  logic [SCALE_W-1:0]      scale_q [NUM_SLOTS];
  logic [TURN_W-1:0]       turn_q  [NUM_SLOTS];
  logic [RAW_W-1:0]        last_q  [NUM_SLOTS];
  logic [POS_W-1:0]        bias_q  [NUM_SLOTS];

  emus_op_e                op_q;
  logic [CH_W-1:0]         ch_q;
  logic [RAW_W-1:0]        raw_q;
  logic [HOME_W-1:0]       home_q;
  logic [TURN_W-1:0]       tn_q;
  logic [POS_W-1:0]        mul_q;
  logic [POS_W-1:0]        ext_q;
  logic [POS_W-1:0]        p0_q;
  logic [PROD_W-1:0]       prod_q;

  logic                    out_valid_q;
  emus_out_t               out_data_q;

  logic                    in_ready;
  logic                    out_load;
  logic                    ch_ok;
  logic [RANGE_W-1:0]      rng;
  logic [TURN_W-1:0]       turn_base;
  logic [RAW_W-1:0]        last_base;
  logic signed [RAW_W:0]   diff;
  logic signed [RAW_W+1:0] diff2;
  logic signed [RAW_W+1:0] rng_s;
  logic signed [RAW_W+1:0] rng_n;
  logic [TURN_W-1:0]       turn_nxt;
  logic [SCALE_W-1:0]      sc;
  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic [POS_W-1:0]        sub_base;
  logic [PROD_W:0]         res_w;
  logic [POS_W-1:0]        res_sat;

  assign ch_ok = {1'b0, in_if.data.channel} < CH_LIMIT;

  // range clamp
  always_comb begin
    if (range_q < RANGE_MIN) begin
      rng = RANGE_MIN;
    end else if (range_q > RANGE_MAX) begin
      rng = RANGE_MAX;
    end else begin
      rng = range_q;
    end
  end

  // wrap rule
  always_comb begin
    turn_base = (op_q == OP_HOME) ? '0 : turn_q[ch_q];
    last_base = (op_q == OP_HOME) ? '0 : last_q[ch_q];
    diff      = $signed({1'b0, last_base}) - $signed({1'b0, raw_q});
    diff2     = {diff, 1'b0};
    rng_s     = $signed({1'b0, rng});
    rng_n     = -rng_s;
    if (diff2 > rng_s) begin
      turn_nxt = turn_base + 32'd1;
    end else if (diff2 < rng_n) begin
      turn_nxt = turn_base - 32'd1;
    end else begin
      turn_nxt = turn_base;
    end
  end

  assign sc    = scale_q[ch_q];
  assign mul_p = mul_a * mul_b;

  // final subtract and saturation
  always_comb begin
    sub_base = (op_q == OP_HOME) ? {{(POS_W-HOME_W){home_q[HOME_W-1]}}, home_q}
                                 : bias_q[ch_q];
    res_w    = {prod_q[PROD_W-1], prod_q}
             - {{(PROD_W-POS_W+1){sub_base[POS_W-1]}}, sub_base};
    if ((&res_w[PROD_W:POS_W-1]) || !(|res_w[PROD_W:POS_W-1])) begin
      res_sat = res_w[POS_W-1:0];
    end else if (res_w[PROD_W]) begin
      res_sat = POS_MIN;
    end else begin
      res_sat = POS_MAX;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_if.valid && ch_ok) begin
          state_d = S_TURN;
        end
      end
      S_TURN: state_d = S_MEXT;
      S_MEXT: state_d = S_ADD;
      S_ADD:  state_d = S_MLO;
      S_MLO:  state_d = S_MHI;
      S_MHI:  state_d = S_SUM;
      S_SUM:  state_d = S_FIN;
      S_FIN: begin
        if (op_q == OP_HOME || !out_valid_q || out_if.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs and multiplier operand select
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    case (state_q)
      S_IDLE: in_ready = 1'b1;
      S_MEXT: begin
        mul_a = $signed({{2{tn_q[TURN_W-1]}}, tn_q});
        mul_b = $signed({1'b0, rng});
      end
      S_MLO: begin
        mul_a = $signed({2'b00, ext_q[31:0]});
        mul_b = $signed({{2{sc[SCALE_W-1]}}, sc});
      end
      S_MHI: begin
        mul_a = $signed({{2{ext_q[POS_W-1]}}, ext_q[63:32]});
        mul_b = $signed({{2{sc[SCALE_W-1]}}, sc});
      end
      S_FIN: out_load = (op_q == OP_SAMPLE) && (!out_valid_q || out_if.ready);
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_data_q;

  // control state, configuration and channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      range_q     <= RANGE_RESET;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        scale_q[i] <= SCALE_RESET;
        turn_q[i]  <= '0;
        last_q[i]  <= '0;
        bias_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (emus_reg_e'(cfg_idx_i))
          REG_RANGE:  range_q    <= cfg_data_i;
          REG_SCALE0: scale_q[0] <= cfg_data_i[SCALE_W-1:0];
          REG_SCALE1: scale_q[1] <= cfg_data_i[SCALE_W-1:0];
          REG_SCALE2: scale_q[2] <= cfg_data_i[SCALE_W-1:0];
          REG_SCALE3: scale_q[3] <= cfg_data_i[SCALE_W-1:0];
          default:    range_q    <= range_q;
        endcase
      end
      if (state_q == S_TURN) begin
        turn_q[ch_q] <= turn_nxt;
        last_q[ch_q] <= raw_q;
      end
      if (state_q == S_FIN && op_q == OP_HOME) begin
        bias_q[ch_q] <= res_sat;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_ready && in_if.valid) begin
      op_q   <= emus_op_e'(in_if.data.opcode);
      ch_q   <= in_if.data.channel;
      raw_q  <= in_if.data.raw_count;
      home_q <= in_if.data.home_value;
    end
    if (state_q == S_TURN) begin
      tn_q <= turn_nxt;
    end
    if (state_q == S_MEXT || state_q == S_MLO || state_q == S_MHI) begin
      mul_q <= mul_p[POS_W-1:0];
    end
    if (state_q == S_ADD) begin
      ext_q <= mul_q + {{(POS_W-RAW_W){1'b0}}, raw_q};
    end
    if (state_q == S_MHI) begin
      p0_q <= mul_q;
    end
    if (state_q == S_SUM) begin
      prod_q <= {mul_q, 32'b0} + {{(PROD_W-POS_W){p0_q[POS_W-1]}}, p0_q};
    end
    if (out_load) begin
      out_data_q.channel_out <= ch_q;
      out_data_q.position    <= res_sat;
    end
  end

  `include "encoder_multiturn_unwrap_scale_top_assert.svh"

  `EMUS_ASSERT_NXT(a_accept_starts, in_if.valid && in_if.ready, state_q == S_TURN || state_q == S_IDLE, "accepted item did not start the sequencer")
  `EMUS_ASSERT_IMP(a_result_from_fin, $rose(out_valid_q), $past(state_q) == S_FIN && $past(op_q) == OP_SAMPLE, "result raised outside the final sample step")
  `EMUS_ASSERT_NXT(a_home_ends, state_q == S_FIN && op_q == OP_HOME, state_q == S_IDLE, "home item did not return to idle")
  `EMUS_ASSERT_NXT(a_turn_step, state_q == S_TURN && op_q == OP_SAMPLE, (turn_q[ch_q] - $past(turn_q[ch_q])) == 32'd0 || (turn_q[ch_q] - $past(turn_q[ch_q])) == 32'd1 || (turn_q[ch_q] - $past(turn_q[ch_q])) == 32'hFFFF_FFFF, "turn count moved by more than one")

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for the encoder unwrap, scale and homing block
`timescale 1ns / 1ps

module tb_top;
  import emus_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_ITEMS   = 120;

  localparam logic [SCALE_W-1:0] SCALE_HI  = 32'h7FFF_FFFF;
  localparam logic [SCALE_W-1:0] SCALE_LO  = 32'h8000_0000;
  localparam logic [RANGE_W-1:0] RANGE_TOP = 33'h1_FFFF_FFFF;
  localparam logic [HOME_W-1:0]  HOME_HI   = 48'h7FFF_FFFF_FFFF;
  localparam logic [HOME_W-1:0]  HOME_LO   = 48'h8000_0000_0000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int err_cnt = 0;

  // range, per-channel state and per-channel scales as the block should hold them
  logic [RANGE_W-1:0] enc_range;
  logic [SCALE_W-1:0] ch_scale [CHANNELS];
  logic [TURN_W-1:0]  turns [CHANNELS];
  logic [RAW_W-1:0]   last_cnt [CHANNELS];
  logic [POS_W-1:0]   bias [CHANNELS];
  emus_out_t          pending_positions [$];

  emus_in_if  in_ch ();
  emus_out_if out_ch ();

  encoder_multiturn_unwrap_scale_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic logic [63:0] eff_range();
    if (enc_range < RANGE_MIN) return 64'(RANGE_MIN);
    if (enc_range > RANGE_MAX) return 64'(RANGE_MAX);
    return 64'(enc_range);
  endfunction

  function automatic logic [POS_W-1:0] clip_q40(input logic signed [127:0] v);
    if (&v[127:63] || ~|v[127:63]) return v[63:0];
    return v[127] ? POS_MIN : POS_MAX;
  endfunction

  // wrap rule, turn extension and exact product with the channel scale
  function automatic logic signed [127:0] scaled_count(input int unsigned ch,
                                                      input logic [RAW_W-1:0] raw);
    logic [63:0]         rng;
    logic signed [65:0]  twice_diff;
    logic signed [65:0]  srng;
    logic [63:0]         ext;
    logic signed [127:0] ext_w;
    logic signed [127:0] sc_w;
    rng = eff_range();
    srng = $signed({2'b0, rng});
    twice_diff = 2 * ($signed({34'b0, last_cnt[ch]}) - $signed({34'b0, raw}));
    if (twice_diff > srng) turns[ch] = turns[ch] + 32'd1;
    else if (twice_diff < -srng) turns[ch] = turns[ch] - 32'd1;
    last_cnt[ch] = raw;
    ext = {{32{turns[ch][31]}}, turns[ch]} * rng + {32'b0, raw};
    ext_w = {{64{ext[63]}}, ext};
    sc_w = {{96{ch_scale[ch][31]}}, ch_scale[ch]};
    return ext_w * sc_w;
  endfunction

  function automatic void unwrap_item(input emus_in_t it);
    logic signed [127:0] prod;
    emus_out_t           res;
    int unsigned         ch;
    ch = it.channel;
    if (it.opcode == OP_HOME) begin
      turns[ch] = '0;
      last_cnt[ch] = '0;
      bias[ch] = '0;
      prod = scaled_count(ch, it.raw_count);
      bias[ch] = clip_q40(prod - {{80{it.home_value[HOME_W-1]}}, it.home_value});
    end else begin
      prod = scaled_count(ch, it.raw_count);
      res.channel_out = it.channel;
      res.position = clip_q40(prod - {{64{bias[ch][63]}}, bias[ch]});
      pending_positions.push_back(res);
    end
  endfunction

  function automatic emus_in_t mk_item(input emus_op_e op, input logic [CH_W-1:0] ch,
                                       input logic [RAW_W-1:0] raw,
                                       input logic [HOME_W-1:0] home);
    emus_in_t it;
    it.opcode = op;
    it.channel = ch;
    it.raw_count = raw;
    it.home_value = home;
    return it;
  endfunction

  // mostly plausible encoder motion, some jumps and raw counts past the range
  function automatic emus_in_t random_item();
    emus_in_t    it;
    logic [63:0] rng;
    logic [63:0] lst;
    logic [63:0] half;
    logic [63:0] r;
    int unsigned sel;
    rng = eff_range();
    half = (rng >> 1) + 64'($urandom_range(2));
    it.channel = CH_W'($urandom_range(CHANNELS - 1));
    it.home_value = HOME_W'({$urandom(), $urandom()});
    it.opcode = ($urandom_range(99) < 10) ? OP_HOME : OP_SAMPLE;
    lst = 64'(last_cnt[it.channel]);
    sel = $urandom_range(99);
    if (sel < 45) r = (lst + rng + 64'($urandom_range(32)) - 64'd16) % rng;
    else if (sel < 60)
      r = ($urandom_range(1) ? 64'($urandom_range(3))
                             : rng - 64'd1 - 64'($urandom_range(3))) % rng;
    else if (sel < 72)
      r = ($urandom_range(1) ? lst + half : lst + rng - half) % rng;
    else if (sel < 90) r = {$urandom(), $urandom()} % rng;
    else r = 64'($urandom());
    it.raw_count = r[RAW_W-1:0];
    return it;
  endfunction

  function automatic logic [SCALE_W-1:0] pick_scale();
    case ($urandom_range(7))
      0: return SCALE_HI;
      1: return SCALE_LO;
      2: return '0;
      3: return SCALE_RESET;
      4: return 32'($urandom_range(33554432)) - SCALE_RESET;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(input emus_in_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.data = it;
    do @(posedge clk_i); while (!in_ch.ready);
    unwrap_item(it);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (pending_positions.size() != 0) @(negedge clk_i);
  endtask

  // home items leave no result behind, so give the sequencer time to finish
  task automatic wait_idle();
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input emus_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_RANGE) enc_range = val;
    else ch_scale[int'(idx) - int'(REG_SCALE0)] = val[SCALE_W-1:0];
  endtask

  task automatic test_wrap_and_saturation();
    wait_idle();
    write_reg(REG_RANGE, RANGE_MAX);
    write_reg(REG_SCALE0, SCALE_HI);
    write_reg(REG_SCALE1, SCALE_LO);
    write_reg(REG_SCALE2, '0);
    send_item(mk_item(OP_SAMPLE, 2'd3, 32'h0, '0));
    send_item(mk_item(OP_SAMPLE, 2'd3, 32'hFFFF_FFFF, '0));
    send_item(mk_item(OP_HOME, 2'd0, 32'h0, '0));
    send_item(mk_item(OP_SAMPLE, 2'd0, 32'h6000_0000, '0));
    send_item(mk_item(OP_SAMPLE, 2'd0, 32'hC000_0000, '0));
    // wraps upward, product beyond the positive limit
    send_item(mk_item(OP_SAMPLE, 2'd0, 32'h2000_0000, '0));
    // exactly half a range back, no turn
    send_item(mk_item(OP_SAMPLE, 2'd0, 32'hA000_0000, '0));
    // home at the top count with the largest home value, the bias stays inside the limits
    send_item(mk_item(OP_HOME, 2'd1, 32'hFFFF_FFFF, HOME_HI));
    send_item(mk_item(OP_SAMPLE, 2'd1, 32'hFFFF_FFFF, '0));
    send_item(mk_item(OP_SAMPLE, 2'd1, 32'h0, '0));
    send_item(mk_item(OP_HOME, 2'd2, 32'h1234_5678, HOME_LO));
    send_item(mk_item(OP_SAMPLE, 2'd2, 32'h0, '0));
  endtask

  task automatic test_range_clamp();
    wait_idle();
    write_reg(REG_RANGE, '0);
    send_item(mk_item(OP_SAMPLE, 2'd3, 32'h0, '0));
    send_item(mk_item(OP_SAMPLE, 2'd3, 32'h1, '0));
    send_item(mk_item(OP_SAMPLE, 2'd3, 32'h0, '0));
    send_item(mk_item(OP_SAMPLE, 2'd3, 32'h5, '0));
    send_item(mk_item(OP_SAMPLE, 2'd3, 32'hFFFF_FFFF, '0));
    send_item(mk_item(OP_HOME, 2'd2, 32'h3, 48'hFFFF_FFFF_FFFF));
    wait_idle();
    write_reg(REG_RANGE, 33'd1);
    send_item(mk_item(OP_SAMPLE, 2'd3, 32'h1, '0));
    send_item(mk_item(OP_SAMPLE, 2'd3, 32'h0, '0));
    wait_idle();
    write_reg(REG_RANGE, RANGE_TOP);
    send_item(mk_item(OP_SAMPLE, 2'd3, 32'h0, '0));
    send_item(mk_item(OP_SAMPLE, 2'd3, 32'h8000_0000, '0));
    send_item(mk_item(OP_SAMPLE, 2'd3, 32'hFFFF_FFFF, '0));
  endtask

  task automatic test_random_traffic(input logic [RANGE_W-1:0] rng, input int n_items);
    wait_idle();
    write_reg(REG_RANGE, rng);
    for (int c = 0; c < CHANNELS; c++)
      write_reg(emus_reg_e'(int'(REG_SCALE0) + c), CFG_DATA_W'(pick_scale()));
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) drain_results();
      send_item(random_item());
    end
  endtask

  always @(negedge clk_i) out_ch.ready = ($urandom_range(99) >= rcv_idle_pct);

  always @(posedge clk_i) begin
    emus_out_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_positions.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected transfer ch %0d position %h", $time,
                 out_ch.data.channel_out, out_ch.data.position);
      end else begin
        want = pending_positions.pop_front();
        if (out_ch.data.channel_out !== want.channel_out) begin
          err_cnt++;
          $display("%0t: channel expected %0d got %0d", $time,
                   want.channel_out, out_ch.data.channel_out);
        end
        if (out_ch.data.position !== want.position) begin
          err_cnt++;
          $display("%0t: position expected %h got %h", $time,
                   want.position, out_ch.data.position);
        end
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_RANGE;
    cfg_data_i = '0;
    enc_range = RANGE_RESET;
    for (int c = 0; c < CHANNELS; c++) begin
      ch_scale[c] = SCALE_RESET;
      turns[c] = '0;
      last_cnt[c] = '0;
      bias[c] = '0;
    end
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    snd_idle_pct = 17;
    rcv_idle_pct = 66;
    test_wrap_and_saturation();
    test_range_clamp();
    test_random_traffic(RANGE_RESET, PHASE_ITEMS);
    test_random_traffic(33'($urandom_range(1000, 2)), PHASE_ITEMS);

    snd_idle_pct = 66;
    rcv_idle_pct = 17;
    test_random_traffic(RANGE_MAX, PHASE_ITEMS);
    test_random_traffic({1'($urandom_range(1)), 32'($urandom())}, PHASE_ITEMS);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_traffic(33'd1, PHASE_ITEMS);
    test_random_traffic(RANGE_TOP, PHASE_ITEMS);

    wait_idle();
    if (err_cnt == 0 && pending_positions.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/emus_pkg.sv
hdl/emus_if.sv
hdl/encoder_multiturn_unwrap_scale_top.sv
verif/tb_top.sv
